### rtl/core/pip_pkg.sv
// Shared constants, codes and control/status types of the point-in-polygon test.
package pip_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int AW           = $clog2(MAX_VERTICES);
	localparam int CW           = $clog2(MAX_VERTICES + 1);
	localparam int CRD_W        = 31;
	localparam int TOL_W        = 21;
	localparam int APB_AW       = 3;

	localparam logic signed [CRD_W-1:0] RAY_FLOOR = {1'b1, {(CRD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_QUERY  = 2'd2
	} req_t;

	typedef enum logic {
		REG_COL_TOL  = 1'b0,
		REG_VERT_TOL = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic          start;
		logic          append;
		logic          query;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          rd_first;
		logic          rd_last;
		logic          out_load;
	} cmd_t;

	typedef struct packed {
		logic [CW-1:0] count;
		logic          busy;
	} sts_t;

endpackage

### rtl/core/point_in_polygon_test.sv
// Top level of the point-in-polygon test: register port, sequencer and datapath.
//
// Requests come in on in_valid/in_stall with req_type, coord_x and coord_y.
// A start request begins a polygon with its first vertex, an append adds
// one (dropped and flagged in table_overflow once the polygon holds 256
// vertices). Neither gives a result. Code 3 is taken and
// ignored. A query walks the stored polygon, one vertex read per cycle
// from the vertex memory, through a four-multiplier edge pipeline, and
// gives one result on out_valid/out_stall: outside, on_edge and
// table_overflow. A query stalls the input until its result is handed off;
// the vertex memory has a single read port. The result sits in
// an output register: a stalled result holds while the next requests are
// taken, and a later query waits at handoff until the register is free.
// Reset clears the vertex count, the overflow flag and all control state
// and sets both tolerance registers to 1. The user writes the tolerances over
// the register port at byte addresses 0 and 4 only while idle (not enforced).
module point_in_polygon_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          req_type,
	input  logic signed [pip_pkg::CRD_W-1:0]    coord_x,
	input  logic signed [pip_pkg::CRD_W-1:0]    coord_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                outside,
	output logic                                on_edge,
	output logic                                table_overflow,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pip_pkg::APB_AW-1:0]          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	pip_pkg::cmd_t              cmd;
	pip_pkg::sts_t              sts;
	logic [pip_pkg::TOL_W-1:0]  col_tol_q, vert_tol_q;
	logic                       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata  = (reg_idx == pip_pkg::REG_VERT_TOL) ?
	                 {{(32-pip_pkg::TOL_W){1'b0}}, vert_tol_q} :
	                 {{(32-pip_pkg::TOL_W){1'b0}}, col_tol_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_tol_q  <= pip_pkg::TOL_W'(1);
			vert_tol_q <= pip_pkg::TOL_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			if (reg_idx == pip_pkg::REG_VERT_TOL) begin
				vert_tol_q <= pwdata[pip_pkg::TOL_W-1:0];
			end else begin
				col_tol_q <= pwdata[pip_pkg::TOL_W-1:0];
			end
		end
	end

	pip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pip_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.col_tol        (col_tol_q),
		.vert_tol       (vert_tol_q),
		.outside        (outside),
		.on_edge        (on_edge),
		.table_overflow (table_overflow)
	);

endmodule

### rtl/core/pip_ctrl.sv
// Sequencer: request intake, vertex walk, pipeline drain and result handoff.
module pip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	output logic              out_valid,
	input  logic              out_stall,
	input  pip_pkg::sts_t     sts,
	output pip_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [pip_pkg::AW-1:0]   k_q;
	logic                     out_valid_q;
	logic                     accept;
	logic                     k_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign k_last    = ({1'b0, k_q} == (sts.count - pip_pkg::CW'(1)));

	always_comb begin
		cmd          = '0;
		cmd.start    = accept && (req_type == pip_pkg::REQ_START);
		cmd.append   = accept && (req_type == pip_pkg::REQ_APPEND);
		cmd.query    = accept && (req_type == pip_pkg::REQ_QUERY);
		cmd.rd_en    = (state_q == ST_WALK);
		cmd.rd_addr  = k_q;
		cmd.rd_first = (k_q == '0);
		cmd.rd_last  = k_last;
		cmd.out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (cmd.query) begin
						state_q <= (sts.count == '0) ? ST_DRAIN : ST_WALK;
					end
				end
				ST_WALK: begin
					k_q <= k_q + pip_pkg::AW'(1);
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !sts.busy)
		else $error("result handed off with edges still in flight");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside of handoff");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && k_last) |=> (state_q == ST_DRAIN))
		else $error("walk did not stop at last vertex");

endmodule

### rtl/core/pip_dp.sv
// Datapath: vertex memory, edge pipeline with cross products, parity and result registers.
module pip_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pip_pkg::cmd_t                    cmd,
	output pip_pkg::sts_t                    sts,
	input  logic signed [pip_pkg::CRD_W-1:0] coord_x,
	input  logic signed [pip_pkg::CRD_W-1:0] coord_y,
	input  logic [pip_pkg::TOL_W-1:0]        col_tol,
	input  logic [pip_pkg::TOL_W-1:0]        vert_tol,
	output logic                             outside,
	output logic                             on_edge,
	output logic                             table_overflow
);

	localparam int W  = pip_pkg::CRD_W;
	localparam int DW = 2 * W;

	logic [DW-1:0]            mem [pip_pkg::MAX_VERTICES];
	logic [DW-1:0]            rd_s1;
	logic                     rdv_s1, rdfirst_s1, rdlast_s1;
	logic [DW-1:0]            prev_q, v0_q;
	logic                     close_q;
	logic [pip_pkg::CW-1:0]   count_q;
	logic                     ovf_q;
	logic signed [W-1:0]      px_q, py_q;
	logic                     on_q, par_q;
	logic                     outside_q, on_edge_q, ovf_out_q;

	logic                     we;
	logic [pip_pkg::AW-1:0]   waddr;

	logic                     ev_s2;
	logic signed [W-1:0]      ax_s2, ay_s2, bx_s2, by_s2;

	logic signed [W:0]        dxa, dybp, dxbp, dyap, dxba, dfa, dyba, dxpa;
	logic [W:0]               adx;
	logic                     xin, yin;

	logic                     ev_s3;
	logic signed [2*W+1:0]    p1_s3, p2_s3, p3_s3, p4_s3;
	logic                     seg_bb_s3, vert_s3, hita_s3, hitb_s3, agtb_s3, meet_bb_s3;
	logic                     bgta_s3;

	logic signed [2*W+2:0]    c, c4;
	logic [2*W+2:0]           cabs;
	logic                     onseg, cross_fail, hit;

	assign we    = cmd.start || (cmd.append && (count_q < pip_pkg::CW'(pip_pkg::MAX_VERTICES)));
	assign waddr = cmd.start ? '0 : count_q[pip_pkg::AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {coord_x, coord_y};
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_q      <= 1'b0;
			rdv_s1     <= 1'b0;
			rdfirst_s1 <= 1'b0;
			rdlast_s1  <= 1'b0;
			close_q    <= 1'b0;
			ev_s2      <= 1'b0;
			ev_s3      <= 1'b0;
			on_q       <= 1'b0;
			par_q      <= 1'b0;
		end else begin
			if (cmd.start) begin
				count_q <= pip_pkg::CW'(1);
				ovf_q   <= 1'b0;
			end else if (cmd.append) begin
				if (we) begin
					count_q <= count_q + pip_pkg::CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			rdv_s1     <= cmd.rd_en;
			rdfirst_s1 <= cmd.rd_first;
			rdlast_s1  <= cmd.rd_last;
			close_q    <= rdv_s1 && rdlast_s1;
			ev_s2      <= (rdv_s1 && !rdfirst_s1) || close_q;
			ev_s3      <= ev_s2;
			if (cmd.query) begin
				on_q  <= 1'b0;
				par_q <= 1'b0;
			end else if (ev_s3) begin
				on_q  <= on_q | onseg;
				par_q <= par_q ^ (!onseg && !vert_s3 && hit);
			end
		end
	end

	// Hold the query point, the previous vertex and the first one for the closing edge.
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (rdv_s1) begin
			prev_q <= rd_s1;
			if (rdfirst_s1) begin
				v0_q <= rd_s1;
			end
		end
		ax_s2 <= prev_q[DW-1:W];
		ay_s2 <= prev_q[W-1:0];
		bx_s2 <= close_q ? v0_q[DW-1:W] : rd_s1[DW-1:W];
		by_s2 <= close_q ? v0_q[W-1:0]  : rd_s1[W-1:0];
	end

	always_comb begin
		dxa  = {ax_s2[W-1], ax_s2} - {px_q[W-1], px_q};
		dxpa = {px_q[W-1], px_q} - {ax_s2[W-1], ax_s2};
		dybp = {by_s2[W-1], by_s2} - {py_q[W-1], py_q};
		dxbp = {bx_s2[W-1], bx_s2} - {px_q[W-1], px_q};
		dyap = {ay_s2[W-1], ay_s2} - {py_q[W-1], py_q};
		dxba = {bx_s2[W-1], bx_s2} - {ax_s2[W-1], ax_s2};
		dfa  = {pip_pkg::RAY_FLOOR[W-1], pip_pkg::RAY_FLOOR} - {ay_s2[W-1], ay_s2};
		dyba = {by_s2[W-1], by_s2} - {ay_s2[W-1], ay_s2};
		adx  = dxba[W] ? (W+1)'(-dxba) : (W+1)'(dxba);
		xin  = (px_q >= ax_s2 && px_q <= bx_s2) || (px_q <= ax_s2 && px_q >= bx_s2);
		yin  = (py_q >= ay_s2 && py_q <= by_s2) || (py_q <= ay_s2 && py_q >= by_s2);
	end

	always_ff @(posedge clk) begin
		p1_s3      <= dxa * dybp;
		p2_s3      <= dxbp * dyap;
		p3_s3      <= dxba * dfa;
		p4_s3      <= dxpa * dyba;
		seg_bb_s3  <= xin && yin;
		vert_s3    <= adx < {{(W+1-pip_pkg::TOL_W){1'b0}}, vert_tol};
		hita_s3    <= (ax_s2 == px_q) && (ay_s2 <= py_q) && (col_tol != '0);
		hitb_s3    <= (bx_s2 == px_q) && (by_s2 <= py_q) && (col_tol != '0);
		agtb_s3    <= ax_s2 > bx_s2;
		bgta_s3    <= bx_s2 > ax_s2;
		meet_bb_s3 <= xin && (py_q >= ay_s2 || py_q >= by_s2);
	end

	// Cross of (a-p, b-p) is the negated cross of (p-a, b-a).
	always_comb begin
		c          = {p1_s3[2*W+1], p1_s3} - {p2_s3[2*W+1], p2_s3};
		c4         = {p3_s3[2*W+1], p3_s3} - {p4_s3[2*W+1], p4_s3};
		cabs       = c[2*W+2] ? (2*W+3)'(-c) : (2*W+3)'(c);
		onseg      = seg_bb_s3 && (cabs < {{(2*W+3-pip_pkg::TOL_W){1'b0}}, col_tol});
		cross_fail = (c[2*W+2] && c4[2*W+2]) ||
		             (!c[2*W+2] && c != '0 && !c4[2*W+2] && c4 != '0);
		if (hita_s3) begin
			hit = agtb_s3;
		end else if (hitb_s3) begin
			hit = bgta_s3;
		end else begin
			hit = meet_bb_s3 && !cross_fail;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			outside_q <= on_q | ~par_q;
			on_edge_q <= on_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign outside        = outside_q;
	assign on_edge        = on_edge_q;
	assign table_overflow = ovf_out_q;
	assign sts.count      = count_q;
	assign sts.busy       = rdv_s1 || close_q || ev_s2 || ev_s3;

endmodule
